// ----- hw/rtl/u8sd_pkg.sv -----
// Shared types and constants for the UTF-8 / Latin-1 stream decoder.
// No dependencies; used by the decode slice and the core.
package u8sd_pkg;

    localparam int CP_W       = 21;
    localparam int BYTE_W     = 8;
    localparam int OUT_TDATA_W = 24;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CP_W-1:0] FLOOR_2B = 21'h000080;
    localparam logic [CP_W-1:0] FLOOR_3B = 21'h000800;
    localparam logic [CP_W-1:0] FLOOR_4B = 21'h010000;

    localparam logic [1:0] SEQ_NONE = 2'd0;
    localparam logic [1:0] SEQ_2B   = 2'd1;
    localparam logic [1:0] SEQ_3B   = 2'd2;
    localparam logic [1:0] SEQ_4B   = 2'd3;

    typedef struct packed {
        logic [CP_W-1:0] accum;
        logic [1:0]      bytes_left;
        logic [1:0]      seq_length;
        logic            halted;
    } t_dec_state;

    typedef struct packed {
        logic            char_valid;
        logic [CP_W-1:0] char_cp;
        logic            end_valid;
    } t_dec_out;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            end_mark;
    } t_result;

endpackage

// ----- hw/rtl/u8sd_decode.sv -----
// Byte decode slice: next decoder state and the results caused by one byte.
// Depends on u8sd_pkg.
module u8sd_decode (
    input  u8sd_pkg::t_dec_state          i_state,
    input  logic [u8sd_pkg::BYTE_W-1:0]   i_byte,
    input  logic                          i_final,
    input  logic                          i_latin1,
    output u8sd_pkg::t_dec_state          o_state,
    output u8sd_pkg::t_dec_out            o_res
);

    u8sd_pkg::t_dec_state lead_st;
    logic                 lead_emit;
    logic [1:0]           bl_dec;
    logic [u8sd_pkg::CP_W-1:0] cont_acc;
    logic [u8sd_pkg::CP_W-1:0] floor_val;
    logic                 is_cont;

    // lead byte decode
    always_comb begin
        lead_st            = '0;
        lead_st.halted     = i_state.halted;
        lead_emit          = 1'b0;
        priority casez (i_byte)
            8'h00: lead_st.halted = 1'b1;
            8'b0???????: lead_emit = 1'b1;
            8'b110?????: begin
                lead_st.accum      = {10'd0, i_byte[4:0], 6'd0};
                lead_st.bytes_left = 2'd1;
                lead_st.seq_length = u8sd_pkg::SEQ_2B;
            end
            8'b1110????: begin
                lead_st.accum      = {5'd0, i_byte[3:0], 12'd0};
                lead_st.bytes_left = 2'd2;
                lead_st.seq_length = u8sd_pkg::SEQ_3B;
            end
            8'b11110???: begin
                lead_st.accum      = {i_byte[2:0], 18'd0};
                lead_st.bytes_left = 2'd3;
                lead_st.seq_length = u8sd_pkg::SEQ_4B;
            end
            default: ;
        endcase
    end

    // continuation byte merge
    always_comb begin
        bl_dec  = i_state.bytes_left - 2'd1;
        is_cont = (i_byte[7:6] == 2'b10) && (i_state.bytes_left != 2'd0);
        unique case (bl_dec)
            2'd0:    cont_acc = i_state.accum | {15'd0, i_byte[5:0]};
            2'd1:    cont_acc = i_state.accum | {9'd0, i_byte[5:0], 6'd0};
            2'd2:    cont_acc = i_state.accum | {3'd0, i_byte[5:0], 12'd0};
            default: cont_acc = i_state.accum;
        endcase
        unique case (i_state.seq_length)
            u8sd_pkg::SEQ_2B: floor_val = u8sd_pkg::FLOOR_2B;
            u8sd_pkg::SEQ_3B: floor_val = u8sd_pkg::FLOOR_3B;
            default:          floor_val = u8sd_pkg::FLOOR_4B;
        endcase
    end

    always_comb begin
        o_state          = i_state;
        o_res.char_valid = 1'b0;
        o_res.char_cp    = {13'd0, i_byte};
        o_res.end_valid  = i_final;
        if (i_latin1) begin
            o_state.accum      = '0;
            o_state.bytes_left = 2'd0;
            o_state.seq_length = u8sd_pkg::SEQ_NONE;
            o_res.char_valid   = 1'b1;
        end else if (!i_state.halted) begin
            if (is_cont) begin
                o_state.bytes_left = bl_dec;
                o_state.accum      = cont_acc;
                if (bl_dec == 2'd0) begin
                    o_res.char_valid   = (cont_acc >= floor_val);
                    o_res.char_cp      = cont_acc;
                    o_state.accum      = '0;
                    o_state.seq_length = u8sd_pkg::SEQ_NONE;
                end
            end else begin
                o_state          = lead_st;
                o_res.char_valid = lead_emit;
            end
        end
        if (i_final) begin
            o_state = '0;
        end
    end

endmodule

// ----- hw/rtl/utf8_stream_decoder_core.sv -----
// Streaming UTF-8 / Latin-1 string decoder core.
// Depends on u8sd_pkg and u8sd_decode.
//
// Usage:
//   s_axis carries one string byte per beat; tlast marks the last byte of the
//   string buffer. m_axis carries one result per beat: a code point, or with
//   tlast high the end-of-string marker (code point zero) that follows the
//   final byte. i_cfg_we/i_cfg_wdata set Latin-1 pass-through mode; write it
//   only between strings while the block is idle.
//   Throughput: one byte per cycle while s_axis_tready is high. A final byte
//   that also yields a character puts two results out; a four-entry result
//   queue absorbs this and s_axis_tready drops only while fewer than two
//   entries are free.
//   When the receiver stalls, results wait in the queue and input stops once
//   it is nearly full; nothing is lost or repeated.
//   Reset clears the decoder state, the mode (UTF-8) and the queue.
module utf8_stream_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // final_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic        m_axis_tlast    // end_mark
);

    u8sd_pkg::t_dec_state r_state;
    u8sd_pkg::t_dec_state n_state;
    u8sd_pkg::t_dec_out   dec_res;
    logic                 r_latin1;

    u8sd_pkg::t_result r_q [u8sd_pkg::QUEUE_DEPTH];
    logic [u8sd_pkg::QPTR_W-1:0] r_wr;
    logic [u8sd_pkg::QPTR_W-1:0] r_rd;
    logic [u8sd_pkg::QCNT_W-1:0] r_count;

    logic              in_fire;
    logic              out_fire;
    logic [1:0]        n_push;
    u8sd_pkg::t_result slot_a;
    u8sd_pkg::t_result slot_b;

    u8sd_decode u_decode (
        .i_state  (r_state),
        .i_byte   (s_axis_tdata),
        .i_final  (s_axis_tlast),
        .i_latin1 (r_latin1),
        .o_state  (n_state),
        .o_res    (dec_res)
    );

    assign s_axis_tready = (r_count <=
        u8sd_pkg::QCNT_W'(u8sd_pkg::QUEUE_DEPTH - 2));
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_count != '0);
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = {3'd0, r_q[r_rd].code_point};
    assign m_axis_tlast  = r_q[r_rd].end_mark;

    always_comb begin
        n_push = in_fire ? ({1'b0, dec_res.char_valid} + {1'b0, dec_res.end_valid}) : 2'd0;
        slot_b.code_point = '0;
        slot_b.end_mark   = 1'b1;
        if (dec_res.char_valid) begin
            slot_a.code_point = dec_res.char_cp;
            slot_a.end_mark   = 1'b0;
        end else begin
            slot_a = slot_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= '0;
            r_latin1 <= 1'b0;
            r_wr     <= '0;
            r_rd     <= '0;
            r_count  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_latin1 <= i_cfg_wdata;
            end
            if (in_fire) begin
                r_state <= n_state;
            end
            r_wr    <= r_wr + u8sd_pkg::QPTR_W'(n_push);
            if (out_fire) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + u8sd_pkg::QCNT_W'(n_push)
                     - u8sd_pkg::QCNT_W'(out_fire);
        end
    end

    // queue payload, no reset
    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) begin
            r_q[r_wr] <= slot_a;
        end
        if (n_push == 2'd2) begin
            r_q[r_wr + 1'b1] <= slot_b;
        end
    end

endmodule

// ----- hw/rtl/u8sd_checker.sv -----
// Port-level checks for the stream decoder core, bound to the top level.
// Depends on utf8_stream_decoder_core.
module u8sd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == 24'd0)
        else $error("end marker beat carries nonzero data");

    a_final_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> m_axis_tvalid)
        else $error("no output after final byte");

endmodule

bind utf8_stream_decoder_core u8sd_checker u_u8sd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for utf8_stream_decoder_core: byte beats in, code points out.
// Depends on u8sd_pkg and the core RTL; carries its own UTF-8 / Latin-1 decode model.
module testbench;

    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_LIMIT    = 2000;
    localparam int PHASE_ITEMS   = 100;
    localparam int SETTLE_CYCLES = 4;
    localparam bit MODE_UTF8     = 1'b0;
    localparam bit MODE_LATIN1   = 1'b1;

    typedef struct packed {
        logic [u8sd_pkg::BYTE_W-1:0] data;
        logic                        last;
    } t_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;     // [7:0] in_byte
    logic        s_axis_tlast = 1'b0;      // final_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;             // [20:0] code_point, [23:21] zero
    logic        m_axis_tlast;             // end_mark

    t_beat             byte_pending[$];
    u8sd_pkg::t_result cp_expected[$];
    int      bytes_queued = 0;
    int      bytes_taken = 0;
    int      fail_count = 0;
    int      idle_cycles = 0;

    bit      in_fire = 1'b0;
    bit      out_fire = 1'b0;

    logic                      mode_latin1 = 1'b0;
    logic [u8sd_pkg::CP_W-1:0] dec_accum = '0;
    logic [1:0]                dec_left = 2'd0;
    logic [1:0]                dec_seq = u8sd_pkg::SEQ_NONE;
    logic                      dec_halted = 1'b0;

    int burst_left = 0;
    int gap_left = 0;
    int rx_span = 0;
    int rx_mode = 0;
    bit hold_go = 1'b0;
    bit hold_done = 1'b0;
    int hold_cnt = 0;

    utf8_stream_decoder_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic emit_cp(input logic [u8sd_pkg::CP_W-1:0] cp, input logic mark);
        u8sd_pkg::t_result r;
        r.code_point = cp;
        r.end_mark   = mark;
        cp_expected  = {cp_expected, r};
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic fin);
        logic [u8sd_pkg::CP_W-1:0] floor_cp;
        if (mode_latin1) begin
            dec_accum = '0;
            dec_left  = 2'd0;
            dec_seq   = u8sd_pkg::SEQ_NONE;
            emit_cp(u8sd_pkg::CP_W'(b), 1'b0);
        end else if (!dec_halted) begin
            if (dec_left == 2'd0 || b == 8'h00 || b[7:6] != 2'b10) begin
                // start a new sequence; a stray byte mid-sequence lands here too
                dec_accum = '0;
                dec_left  = 2'd0;
                dec_seq   = u8sd_pkg::SEQ_NONE;
                if (b == 8'h00) begin
                    dec_halted = 1'b1;
                end else if (!b[7]) begin
                    emit_cp(u8sd_pkg::CP_W'(b), 1'b0);
                end else if (b[7:5] == 3'b110) begin
                    dec_accum = u8sd_pkg::CP_W'(b[4:0]) << 6;
                    dec_left  = 2'd1;
                    dec_seq   = u8sd_pkg::SEQ_2B;
                end else if (b[7:4] == 4'b1110) begin
                    dec_accum = u8sd_pkg::CP_W'(b[3:0]) << 12;
                    dec_left  = 2'd2;
                    dec_seq   = u8sd_pkg::SEQ_3B;
                end else if (b[7:3] == 5'b11110) begin
                    dec_accum = u8sd_pkg::CP_W'(b[2:0]) << 18;
                    dec_left  = 2'd3;
                    dec_seq   = u8sd_pkg::SEQ_4B;
                end
            end else begin
                dec_left  = dec_left - 2'd1;
                dec_accum = dec_accum | (u8sd_pkg::CP_W'(b[5:0]) << (6 * dec_left));
                if (dec_left == 2'd0) begin
                    floor_cp = (dec_seq == u8sd_pkg::SEQ_2B) ? u8sd_pkg::FLOOR_2B :
                               (dec_seq == u8sd_pkg::SEQ_3B) ? u8sd_pkg::FLOOR_3B :
                               u8sd_pkg::FLOOR_4B;
                    if (dec_accum >= floor_cp) begin
                        emit_cp(dec_accum, 1'b0);
                    end
                    dec_accum = '0;
                    dec_seq   = u8sd_pkg::SEQ_NONE;
                end
            end
        end
        if (fin) begin
            emit_cp('0, 1'b1);
            dec_accum  = '0;
            dec_left   = 2'd0;
            dec_seq    = u8sd_pkg::SEQ_NONE;
            dec_halted = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        u8sd_pkg::t_result exp_r;
        in_fire  = i_rst_n && s_axis_tvalid && s_axis_tready;
        out_fire = i_rst_n && m_axis_tvalid && m_axis_tready;
        if (i_rst_n && i_cfg_we) begin
            mode_latin1 = i_cfg_wdata;
        end
        if (in_fire) begin
            decode_byte(s_axis_tdata, s_axis_tlast);
            bytes_taken++;
        end
        if (out_fire) begin
            if (cp_expected.size() == 0) begin
                $error("unexpected result: code_point 0x%06h end_mark %0b",
                       m_axis_tdata[u8sd_pkg::CP_W-1:0], m_axis_tlast);
                fail_count++;
            end else begin
                exp_r = cp_expected.pop_front();
                if (m_axis_tdata[u8sd_pkg::CP_W-1:0] !== exp_r.code_point) begin
                    $error("code_point: expected 0x%06h, got 0x%06h",
                           exp_r.code_point, m_axis_tdata[u8sd_pkg::CP_W-1:0]);
                    fail_count++;
                end
                if (m_axis_tlast !== exp_r.end_mark) begin
                    $error("end_mark: expected %0b, got %0b", exp_r.end_mark, m_axis_tlast);
                    fail_count++;
                end
            end
        end
        if (!i_rst_n || in_fire || out_fire) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // sender: bursts of beats separated by random gaps
    always @(negedge i_clk) begin
        t_beat nb;
        if (i_rst_n && (!s_axis_tvalid || in_fire)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (byte_pending.size() > 0) begin
                nb = byte_pending.pop_front();
                s_axis_tdata  <= nb.data;
                s_axis_tlast  <= nb.last;
                s_axis_tvalid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: own stall pattern, plus one long hold-off on request
    always @(negedge i_clk) begin
        logic rdy;
        if (hold_go && !hold_done) begin
            rdy = 1'b0;
            hold_cnt++;
            if (hold_cnt >= HOLD_CYCLES) begin
                hold_done = 1'b1;
            end
        end else begin
            if (rx_span == 0) begin
                rx_mode = $urandom_range(0, 2);
                rx_span = $urandom_range(8, 64);
            end else begin
                rx_span--;
            end
            case (rx_mode)
                0: begin
                    rdy = 1'b1;
                end
                1: begin
                    rdy = 1'($urandom_range(0, 1));
                end
                default: begin
                    rdy = ($urandom_range(0, 3) == 0);
                end
            endcase
        end
        m_axis_tready <= rdy;
    end

    task automatic queue_byte(input logic [7:0] b, input logic last);
        t_beat nb;
        nb.data = b;
        nb.last = last;
        byte_pending = {byte_pending, nb};
        bytes_queued++;
    endtask

    // encode cp in len bytes, keeping only the first keep of them
    task automatic queue_seq(input logic [u8sd_pkg::CP_W-1:0] cp, input int len,
                             input int keep);
        logic [7:0] lead;
        case (len)
            1:       lead = {1'b0, cp[6:0]};
            2:       lead = {3'b110, cp[10:6]};
            3:       lead = {4'b1110, cp[15:12]};
            default: lead = {5'b11110, cp[20:18]};
        endcase
        queue_byte(lead, 1'b0);
        for (int i = 1; i < keep; i++) begin
            queue_byte({2'b10, 6'(cp >> (6 * (len - 1 - i)))}, 1'b0);
        end
    endtask

    task automatic queue_char();
        int kind;
        int len;
        logic [u8sd_pkg::CP_W-1:0] cp;
        kind = $urandom_range(0, 99);
        len  = $urandom_range(1, 4);
        case (len)
            1:       cp = u8sd_pkg::CP_W'($urandom_range(1, 'h7F));
            2:       cp = u8sd_pkg::CP_W'($urandom_range('h80, 'h7FF));
            3:       cp = u8sd_pkg::CP_W'($urandom_range('h800, 'hFFFF));
            default: cp = u8sd_pkg::CP_W'($urandom_range('h10000, 'h1FFFFF));
        endcase
        if (kind < 3) begin
            queue_byte(8'h00, 1'b0);
        end else if (kind < 11) begin
            queue_byte(8'($urandom_range(0, 255)), 1'b0);
        end else if (kind < 16) begin
            len = $urandom_range(2, 4);
            cp  = u8sd_pkg::CP_W'($urandom_range(0,
                      (len == 2) ? 'h7F : (len == 3) ? 'h7FF : 'hFFFF));
            queue_seq(cp, len, len);
        end else if (kind < 21 && len > 1) begin
            queue_seq(cp, len, $urandom_range(1, len - 1));
        end else begin
            queue_seq(cp, len, len);
        end
    endtask

    task automatic queue_string(input bit with_final);
        int n;
        n = $urandom_range(1, 12);
        repeat (n) begin
            queue_char();
        end
        if (with_final) begin
            byte_pending[byte_pending.size() - 1].last = 1'b1;
        end
    endtask

    task automatic write_mode(input logic v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic finish_phase();
        while (bytes_taken != bytes_queued || cp_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        bit phase_mode[6];
        int start;
        phase_mode = '{MODE_UTF8, MODE_LATIN1, MODE_UTF8, MODE_LATIN1, MODE_UTF8, MODE_UTF8};
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // UTF-8: each length, max value, overlong, bad leads, broken, surrogate and zero-byte halt
        write_mode(MODE_UTF8);
        queue_byte(8'h41, 1'b0);
        queue_byte(8'hC3, 1'b0); queue_byte(8'hA9, 1'b0);
        queue_byte(8'hE2, 1'b0); queue_byte(8'h82, 1'b0); queue_byte(8'hAC, 1'b0);
        queue_byte(8'hF7, 1'b0); queue_byte(8'hBF, 1'b0);
        queue_byte(8'hBF, 1'b0); queue_byte(8'hBF, 1'b0);
        queue_byte(8'hE0, 1'b0); queue_byte(8'h80, 1'b0); queue_byte(8'h80, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hC3, 1'b0); queue_byte(8'h41, 1'b0);
        queue_byte(8'hED, 1'b0); queue_byte(8'hA0, 1'b0); queue_byte(8'h80, 1'b0);
        queue_byte(8'hC2, 1'b1);
        queue_byte(8'h00, 1'b0); queue_byte(8'h42, 1'b0);
        finish_phase();
        // Latin-1 while halted, zero byte passes through
        write_mode(MODE_LATIN1);
        queue_byte(8'hFF, 1'b0); queue_byte(8'h00, 1'b1);
        finish_phase();
        // open a partial sequence, then drop it by switching to Latin-1
        write_mode(MODE_UTF8);
        queue_byte(8'hE2, 1'b0); queue_byte(8'h82, 1'b0);
        finish_phase();
        write_mode(MODE_LATIN1);
        queue_byte(8'h41, 1'b1);
        finish_phase();

        for (int p = 0; p < 6; p++) begin
            write_mode(phase_mode[p]);
            if (p == 2) begin
                hold_go = 1'b1;
            end
            start = bytes_queued;
            while (bytes_queued - start < PHASE_ITEMS) begin
                queue_string(1'b1);
            end
            queue_string((p == 5) ? 1'b1 : bit'($urandom_range(0, 1)));
            finish_phase();
        end

        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
